### src/cprtl_pkg.sv
// shared types and constants for the codepoint range table lookup unit
package cprtl_pkg;

  localparam int TABLE_DEPTH_DEF      = 4096;
  localparam int GLYPH_INDEX_BITS_DEF = 18;

  localparam int CP_W    = 21;
  localparam int BASE_W  = 18;
  localparam int IDX_W   = 12;
  localparam int COUNT_W = 13;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CP_W-1:0]   first;
    logic [CP_W-1:0]   last;
    logic [BASE_W-1:0] base;
  } range_t;

  typedef struct packed {
    logic wr_item;
    logic lookup_item;
    logic check;
    logic step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic last_hit;
    logic search_end;
  } dp_status_t;

endpackage

### src/cprtl_ctrl.sv
// sequencer for write and lookup words: check, probe loop and output register
module cprtl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  kind_i,
  output logic                  in_stall_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output cprtl_pkg::dp_cmd_t    cmd_o,
  input  cprtl_pkg::dp_status_t status_i
);
  import cprtl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_DONE
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    accept;
  logic    out_free;
  dp_cmd_t cmd;

  always_comb begin
    in_stall_o      = (state_q != ST_IDLE);
    accept          = in_valid_i & ~in_stall_o;
    out_free        = ~out_valid_q | ~out_stall_i;
    cmd             = '0;
    cmd.wr_item     = accept & (kind_i == KIND_WRITE);
    cmd.lookup_item = accept & (kind_i == KIND_LOOKUP);
    cmd.check       = (state_q == ST_CHECK);
    cmd.step        = (state_q == ST_SEARCH);
    cmd.load_out    = (state_q == ST_DONE) & out_free;

    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd.lookup_item) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.empty || status_i.last_hit) state_d = ST_DONE;
        else                                     state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status_i.search_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // result word leaves when taken, a new one enters from the done state
    if (cmd.load_out)     out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else                  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

endmodule

### src/cprtl_dp.sv
// range table memory, last-hit register, binary search bounds and result registers
module cprtl_dp #(
  parameter int TABLE_DEPTH      = cprtl_pkg::TABLE_DEPTH_DEF,
  parameter int GLYPH_INDEX_BITS = cprtl_pkg::GLYPH_INDEX_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cprtl_pkg::dp_cmd_t                cmd_i,
  output cprtl_pkg::dp_status_t             status_o,
  input  logic                              cfg_we_i,
  input  logic [cprtl_pkg::COUNT_W-1:0]     cfg_wdata_i,
  input  logic [cprtl_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [cprtl_pkg::CP_W-1:0]        range_first_i,
  input  logic [cprtl_pkg::CP_W-1:0]        range_last_i,
  input  logic [cprtl_pkg::BASE_W-1:0]      glyph_base_i,
  input  logic [cprtl_pkg::CP_W-1:0]        codepoint_i,
  output logic                              found_o,
  output logic [GLYPH_INDEX_BITS-1:0]       glyph_index_o
);
  import cprtl_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  range_t mem [TABLE_DEPTH];
  range_t rd_q;

  logic [CNT_W-1:0]            count_q, count_d;
  logic                        hit_valid_q;
  logic [CP_W-1:0]             hit_first_q, hit_last_q;
  logic [BASE_W-1:0]           hit_base_q;
  logic [CP_W-1:0]             cp_q;
  logic [CNT_W-1:0]            lo_q, hix_q, mid_q;
  logic [CNT_W-1:0]            mid_init, mid_l, mid_r;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic                        wr_en, rd_en;
  logic                        go_left, go_right, probe_hit, probe_miss;
  logic                        left_empty, right_empty;
  logic                        last_hit, empty;
  logic [CP_W-1:0]             first_sel, offset, sum;
  logic [BASE_W-1:0]           base_sel;
  logic                        res_found_q, out_found_q;
  logic [GLYPH_INDEX_BITS-1:0] res_glyph_q, out_glyph_q, glyph;

  // count register clamps to the table depth
  always_comb begin
    if (32'(cfg_wdata_i) > 32'(TABLE_DEPTH)) count_d = CNT_W'(TABLE_DEPTH);
    else                                     count_d = CNT_W'(cfg_wdata_i);
  end

  always_comb begin
    wr_addr = AW'(entry_index_i);
    wr_en   = cmd_i.wr_item & (32'(entry_index_i) < 32'(TABLE_DEPTH));

    empty    = (count_q == '0);
    last_hit = hit_valid_q & (cp_q >= hit_first_q) & (cp_q <= hit_last_q);

    // rd_q holds the entry at mid_q during a probe cycle
    go_left     = (cp_q < rd_q.first);
    go_right    = ~go_left & (cp_q > rd_q.last);
    probe_hit   = ~go_left & ~go_right;
    left_empty  = (lo_q == mid_q);
    right_empty = ((mid_q + CNT_W'(1)) >= hix_q);
    probe_miss  = (go_left & left_empty) | (go_right & right_empty);

    // next midpoints for both outcomes, upper bound kept exclusive
    mid_init = (count_q - CNT_W'(1)) >> 1;
    mid_l    = lo_q + ((mid_q - CNT_W'(1) - lo_q) >> 1);
    mid_r    = mid_q + CNT_W'(1) + ((hix_q - mid_q - CNT_W'(2)) >> 1);

    rd_en = cmd_i.check | cmd_i.step;
    if (cmd_i.check)  rd_addr = mid_init[AW-1:0];
    else if (go_left) rd_addr = mid_l[AW-1:0];
    else              rd_addr = mid_r[AW-1:0];

    // one shared subtractor and adder serve the last-hit path and the probe path
    first_sel = cmd_i.check ? hit_first_q : rd_q.first;
    base_sel  = cmd_i.check ? hit_base_q : rd_q.base;
    offset    = cp_q - first_sel;
    sum       = CP_W'(base_sel) + offset;
    glyph     = sum[GLYPH_INDEX_BITS-1:0];

    status_o.empty      = empty;
    status_o.last_hit   = last_hit;
    status_o.search_end = probe_hit | probe_miss;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{first: range_first_i, last: range_last_i, base: glyph_base_i};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hit_valid_q <= 1'b0;
      hit_first_q <= '0;
      hit_last_q  <= '0;
      hit_base_q  <= '0;
    end else begin
      if (cfg_we_i) count_q <= count_d;
      if (cfg_we_i || cmd_i.wr_item) begin
        hit_valid_q <= 1'b0;
      end else if (cmd_i.step && probe_hit) begin
        hit_valid_q <= 1'b1;
        hit_first_q <= rd_q.first;
        hit_last_q  <= rd_q.last;
        hit_base_q  <= rd_q.base;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup_item) cp_q <= codepoint_i;

    if (cmd_i.check) begin
      lo_q  <= '0;
      hix_q <= count_q;
      mid_q <= mid_init;
    end else if (cmd_i.step) begin
      if (go_left) begin
        hix_q <= mid_q;
        mid_q <= mid_l;
      end else if (go_right) begin
        lo_q  <= mid_q + CNT_W'(1);
        mid_q <= mid_r;
      end
    end

    if (cmd_i.check) begin
      if (empty) begin
        res_found_q <= 1'b0;
        res_glyph_q <= '0;
      end else begin
        res_found_q <= last_hit;
        res_glyph_q <= glyph;
      end
    end else if (cmd_i.step) begin
      res_found_q <= probe_hit;
      res_glyph_q <= probe_hit ? glyph : '0;
    end

    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_glyph_q <= res_glyph_q;
    end
  end

  assign found_o       = out_found_q;
  assign glyph_index_o = out_glyph_q;

endmodule

### src/codepoint_range_table_lookup_unit.sv
// lookup word of a codepoint against a sorted range table with last-hit register
// write word: written to the table when accepted, no result word; the next word can follow at once
// lookup word: accept, last-hit check, probes unless it hits or the table is empty
// (up to ceil(log2(count+1)) probes, 13 at 4096 entries), then the output register
// the next word waits on in_stall_o until the result enters the output register
// reset clears count and last-hit register; table contents are undefined until written
module codepoint_range_table_lookup_unit #(
  parameter int TABLE_DEPTH      = cprtl_pkg::TABLE_DEPTH_DEF,
  parameter int GLYPH_INDEX_BITS = cprtl_pkg::GLYPH_INDEX_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cprtl_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [cprtl_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [cprtl_pkg::CP_W-1:0]    range_first_i,
  input  logic [cprtl_pkg::CP_W-1:0]    range_last_i,
  input  logic [cprtl_pkg::BASE_W-1:0]  glyph_base_i,
  input  logic [cprtl_pkg::CP_W-1:0]    codepoint_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [GLYPH_INDEX_BITS-1:0]   glyph_index_o
);
  import cprtl_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cprtl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cprtl_dp #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .GLYPH_INDEX_BITS (GLYPH_INDEX_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .glyph_base_i  (glyph_base_i),
    .codepoint_i   (codepoint_i),
    .found_o       (found_o),
    .glyph_index_o (glyph_index_o)
  );

endmodule
